/* sv/mm4x4_pkg.sv */
// shared types and constants for the 4x4 fixed-point matrix multiplier
package mm4x4_pkg;

  // element format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = PROD_W + 2;

  // matrix geometry
  localparam int DIM      = 4;
  localparam int ELEMS    = DIM * DIM;
  localparam int IDX_W    = $clog2(ELEMS);
  localparam int DIM_W    = $clog2(DIM);

  // stream packing
  localparam int IN_TDATA_W  = ((IDX_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int OP_W        = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_WR_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

  // sequencer steps within one product element
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_FIRST_ACC = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LAST_MUL  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LAST_ACC  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LOAD      = 3'd5;

  localparam logic [IDX_W-1:0] LAST_ELEM = IDX_W'(ELEMS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_OUT
  } state_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clear;
  } mac_ctrl_t;

endpackage

/* sv/matrix_multiply_4x4_top.sv */
// 4x4 signed fixed-point matrix multiplier, top level with sequencer and stores
// element writes are stored on each accepted transfer; in_tready is high only while idle
// a multiply request emits 16 results; each is computed on the single shared
// multiplier (4 products, an accumulate drain, then a shift/saturate load into
// the output register), where it waits until out_tready accepts it
// synchronous active-low reset clears both matrices to zero and the sequencer to idle
module matrix_multiply_4x4_top
  import mm4x4_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // element_index, value, zero pad
  input  logic [OP_W-1:0]        in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // element_index_res, value_res, zero pad
  output logic                   out_tlast
);

  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [IDX_W-1:0]      elem_r, elem_nxt;
  logic [DATA_WIDTH-1:0] left_r  [ELEMS];
  logic [DATA_WIDTH-1:0] right_r [ELEMS];
  logic [DATA_WIDTH-1:0] out_value_r;
  logic                  out_load;
  mac_ctrl_t             mac_ctrl;

  logic                  in_fire;
  logic                  out_fire;
  logic [IDX_W-1:0]      in_index;
  logic [DATA_WIDTH-1:0] in_value;
  logic [DIM_W-1:0]      row, col, kk;
  logic [IDX_W-1:0]      left_addr, right_addr;
  logic signed [DATA_WIDTH-1:0] mac_a, mac_b, mac_result;

  assign in_index = in_tdata[IDX_W-1:0];
  assign in_value = in_tdata[IDX_W+DATA_WIDTH-1:IDX_W];
  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  // element stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ELEMS; i++) begin
        left_r[i]  <= '0;
        right_r[i] <= '0;
      end
    end else if (in_fire) begin
      case (in_tuser)
        OP_WR_LEFT:  left_r[in_index]  <= in_value;
        OP_WR_RIGHT: right_r[in_index] <= in_value;
        default: ;
      endcase
    end
  end

  // operand addresses: left(row,k) and right(k,col), column-major
  assign row        = elem_r[DIM_W-1:0];
  assign col        = elem_r[IDX_W-1:DIM_W];
  assign kk         = step_r[DIM_W-1:0];
  assign left_addr  = {kk, row};
  assign right_addr = {col, kk};
  assign mac_a      = left_r[left_addr];
  assign mac_b      = right_r[right_addr];

  mm4x4_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .a         (mac_a),
    .b         (mac_b),
    .sat_value (mac_result)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      elem_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      elem_r  <= elem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mac_result;
    end
  end

  // next state and control
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    elem_nxt  = elem_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    mac_ctrl  = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // ready is high throughout idle, so valid alone marks the transfer
        if (in_tvalid && (in_tuser == OP_MULTIPLY)) begin
          state_nxt = ST_MAC;
          step_nxt  = '0;
          elem_nxt  = '0;
        end
      end
      ST_MAC: begin
        mac_ctrl.mul_en    = (step_r <= STEP_LAST_MUL);
        mac_ctrl.acc_en    = (step_r >= STEP_FIRST_ACC) && (step_r <= STEP_LAST_ACC);
        mac_ctrl.acc_clear = (step_r == STEP_FIRST_ACC);
        step_nxt           = step_r + 1'b1;
        if (step_r == STEP_LOAD) begin
          out_load  = 1'b1;
          state_nxt = ST_OUT;
          step_nxt  = '0;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          if (elem_r == LAST_ELEM) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            elem_nxt  = elem_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result channel
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = (elem_r == LAST_ELEM);
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W - DATA_WIDTH){1'b0}}, out_value_r, elem_r};

endmodule

/* sv/mm4x4_mac.sv */
// shared multiply-accumulate unit with fixed-point shift and saturation
module mm4x4_mac
  import mm4x4_pkg::*;
(
  input  logic                         clk,
  input  mac_ctrl_t                    ctrl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] sat_value
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_WIDTH:0] hi_bits;

  // single shared multiplier, registered
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= a * b;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // accumulator, loaded with the first term of each element
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      if (ctrl.acc_clear) begin
        acc_r <= prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  // drop fraction bits and clamp to the element range
  assign shifted = acc_r >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:DATA_WIDTH-1];

  always_comb begin
    if ((hi_bits == '0) || (hi_bits == '1)) begin
      sat_value = shifted[DATA_WIDTH-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

endmodule
